// ===== sv/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, masked during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg
// shared widths and types for the vector normalizer
// ----------------------------------------------------------------------------
package v3n_pkg;
   localparam int COMP_W = 32;
   localparam int UNIT_W = 18;
   localparam int TINY_W = 16;
   localparam int SQ_W   = 64;
   localparam int LEN_W  = 32;
   localparam logic signed [UNIT_W-1:0] UNIT_MAX = 18'sd131071;

   typedef struct packed {
      logic [COMP_W-1:0] mag;
      logic              neg;
   } lane_type;
endpackage

// ===== sv/v3n_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3n_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module v3n_sqrt
   import v3n_pkg::*;
#(
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_vld,
   input  logic [SQ_W-1:0]  in_val,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_vld,
   output logic [LEN_W-1:0] out_root,
   output logic [TAG_W-1:0] out_tag
);
   localparam int N = LEN_W;

   logic [SQ_W-1:0]  rem_ff  [N+1];
   logic [LEN_W-1:0] root_ff [N+1];
   logic [TAG_W-1:0] tag_ff  [N+1];
   logic             vld_ff  [N+1];

   always_comb begin
      rem_ff[0]  = in_val;
      root_ff[0] = '0;
      tag_ff[0]  = in_tag;
      vld_ff[0]  = in_vld;
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam int B = N - 1 - s;
      logic [SQ_W+1:0] trial;
      logic [SQ_W-1:0] rem_in;
      logic [LEN_W-1:0] root_in;
      always_comb begin
         // trial = (2*root*2^B + 2^(2B)) compared with remainder
         trial = ({2'b0, 32'b0, root_ff[s]} << (B + 1)) + ({2'b0, 64'd1} << (2 * B));
         if ({2'b0, rem_ff[s]} >= trial) begin
            rem_in  = rem_ff[s] - trial[SQ_W-1:0];
            root_in = root_ff[s] | (LEN_W'(1) << B);
         end else begin
            rem_in  = rem_ff[s];
            root_in = root_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (adv) begin
            rem_ff[s+1]  <= rem_in;
            root_ff[s+1] <= root_in;
            tag_ff[s+1]  <= tag_ff[s];
         end
      end
   end

   assign out_vld  = vld_ff[N];
   assign out_root = root_ff[N];
   assign out_tag  = tag_ff[N];
endmodule

// ===== sv/v3n_div_lane.sv =====
// ----------------------------------------------------------------------------
// v3n_div_lane
// one lane: pipelined restoring divide of a component by the length
// ----------------------------------------------------------------------------
module v3n_div_lane
   import v3n_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             adv,
   input  lane_type         in_lane,
   input  logic [LEN_W-1:0] in_len,
   output logic [UNIT_W-1:0] out_unit
);
   // quotient is at most 2^FRAC_BITS, FRAC_BITS+1 bits
   localparam int QB = FRAC_BITS + 1;
   localparam int RW = LEN_W + 1;

   logic [RW-1:0]    rem_ff [QB+1];
   logic [LEN_W-1:0] den_ff [QB+1];
   logic [QB-1:0]    quo_ff [QB+1];
   logic             neg_ff [QB+1];

   always_comb begin
      // mag <= len, so the leading part is mag itself with the top quotient bits zero
      rem_ff[0] = {1'b0, in_lane.mag};
      den_ff[0] = in_len;
      quo_ff[0] = '0;
      neg_ff[0] = in_lane.neg;
   end

   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic [RW-1:0] cand;
      logic [RW-1:0] rem_in;
      logic          bit_q;
      always_comb begin
         if (s == 0) begin
            cand = rem_ff[s];
         end else begin
            cand = {rem_ff[s][RW-2:0], 1'b0};
         end
         bit_q  = cand >= {1'b0, den_ff[s]};
         rem_in = bit_q ? cand - {1'b0, den_ff[s]} : cand;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= {quo_ff[s][QB-2:0], bit_q};
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   logic [UNIT_W-1:0] sat;
   always_comb begin
      if ({{(32-QB){1'b0}}, quo_ff[QB]} > 32'(UNIT_MAX)) begin
         sat = UNIT_MAX;
      end else begin
         sat = UNIT_W'(quo_ff[QB]);
      end
      out_unit = neg_ff[QB] ? (~sat + 1'b1) : sat;
   end
endmodule

// ===== sv/vector3_normalize.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize
// normalizes a signed fixed-point 3-vector and reports its length
// ----------------------------------------------------------------------------
// Accepts one vector every cycle while req_stall is low. The pipeline has
// one square stage, a 32-stage square root pipeline, three parallel
// divide lanes of FRAC_BITS + 1 stages and an output register. The whole
// pipeline advances while the output register is empty or being taken.
module vector3_normalize
   import v3n_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [TINY_W-1:0]        csr_tiny_length,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COMP_W-1:0] req_comp_x,
   input  logic signed [COMP_W-1:0] req_comp_y,
   input  logic signed [COMP_W-1:0] req_comp_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [UNIT_W-1:0] rsp_unit_x,
   output logic signed [UNIT_W-1:0] rsp_unit_y,
   output logic signed [UNIT_W-1:0] rsp_unit_z,
   output logic [LEN_W-1:0]         rsp_length,
   output logic                     rsp_fell_back
);
   localparam int QB = FRAC_BITS + 1;
   localparam int TAG_W = 3 * (COMP_W + 1);

   logic [TINY_W-1:0] tiny_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tiny_ff <= '0;
      end else if (csr_write) begin
         tiny_ff <= csr_tiny_length;
      end
   end

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   lane_type lane_in [3];
   logic [COMP_W-1:0] comps [3];
   assign comps[0] = req_comp_x;
   assign comps[1] = req_comp_y;
   assign comps[2] = req_comp_z;

   lane_type          sq_lane_ff [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic              sq_vld_ff;
   for (genvar i = 0; i < 3; i++) begin : g_sq
      always_comb begin
         lane_in[i].neg = comps[i][COMP_W-1];
         lane_in[i].mag = comps[i][COMP_W-1] ? (~comps[i] + 1'b1) : comps[i];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_lane_ff[i] <= lane_in[i];
            sq_ff[i]      <= SQ_W'(lane_in[i].mag) * SQ_W'(lane_in[i].mag);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else if (adv) begin
         sq_vld_ff <= req_valid;
      end
   end

   logic [SQ_W-1:0]  sum;
   logic [TAG_W-1:0] tag_in, tag_out;
   assign sum    = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign tag_in = {sq_lane_ff[0], sq_lane_ff[1], sq_lane_ff[2]};

   logic             rt_vld;
   logic [LEN_W-1:0] rt_len;
   v3n_sqrt #(.TAG_W(TAG_W)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (sq_vld_ff),
      .in_val  (sum),
      .in_tag  (tag_in),
      .out_vld (rt_vld),
      .out_root(rt_len),
      .out_tag (tag_out)
   );

   lane_type rt_lane [3];
   assign rt_lane[0] = tag_out[TAG_W-1 -: COMP_W+1];
   assign rt_lane[1] = tag_out[2*(COMP_W+1)-1 -: COMP_W+1];
   assign rt_lane[2] = tag_out[COMP_W:0];

   // safe divisor avoids zero; fallback overrides those results
   logic [LEN_W-1:0] div_len;
   assign div_len = (rt_len == '0) ? LEN_W'(1) : rt_len;

   logic [UNIT_W-1:0] unit [3];
   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3n_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock   (clock),
         .adv     (adv),
         .in_lane (rt_lane[i]),
         .in_len  (div_len),
         .out_unit(unit[i])
      );
   end

   // side pipeline for length, fallback and valid
   logic [LEN_W-1:0] len_ff  [QB+1];
   logic             fb_ff   [QB+1];
   logic             vld_ff  [QB+1];
   always_comb begin
      len_ff[0] = rt_len;
      fb_ff[0]  = rt_len <= {{(LEN_W-TINY_W){1'b0}}, tiny_ff};
      vld_ff[0] = rt_vld;
   end
   for (genvar s = 0; s < QB; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (adv) begin
            len_ff[s+1] <= len_ff[s];
            fb_ff[s+1]  <= fb_ff[s];
         end
      end
   end

   logic [UNIT_W-1:0] one_sat;
   assign one_sat = (FRAC_BITS >= UNIT_W - 1) ? UNIT_MAX : UNIT_W'(1) << FRAC_BITS;

   logic              rsp_valid_ff;
   logic [UNIT_W-1:0] ux_ff, uy_ff, uz_ff;
   logic [LEN_W-1:0]  len_out_ff;
   logic              fb_out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[QB];
      end
      if (adv) begin
         ux_ff      <= fb_ff[QB] ? '0 : unit[0];
         uy_ff      <= fb_ff[QB] ? one_sat : unit[1];
         uz_ff      <= fb_ff[QB] ? '0 : unit[2];
         len_out_ff <= len_ff[QB];
         fb_out_ff  <= fb_ff[QB];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_unit_x    = ux_ff;
   assign rsp_unit_y    = uy_ff;
   assign rsp_unit_z    = uz_ff;
   assign rsp_length    = len_out_ff;
   assign rsp_fell_back = fb_out_ff;
endmodule

// ===== sv/v3n_checker.sv =====
// ----------------------------------------------------------------------------
// v3n_checker
// port-level checks for the vector normalizer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module v3n_checker
   import v3n_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [UNIT_W-1:0] rsp_unit_x,
   input logic signed [UNIT_W-1:0] rsp_unit_z,
   input logic [LEN_W-1:0]         rsp_length,
   input logic                     rsp_fell_back
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_length))
   `ASSERT_IMPLY(a_stall_only_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ASSERT_IMPLY(a_fb_zero, clock, reset, rsp_valid && rsp_fell_back, rsp_unit_x == '0 && rsp_unit_z == '0)
   `ASSERT_IMPLY(a_zero_len_fb, clock, reset, rsp_valid && rsp_length == '0, rsp_fell_back)
endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_unit_x   (rsp_unit_x),
   .rsp_unit_z   (rsp_unit_z),
   .rsp_length   (rsp_length),
   .rsp_fell_back(rsp_fell_back)
);

// ===== sim/vector3_normalize_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_normalize_tb
// self-checking bench for the fixed-point vector normalizer
// ----------------------------------------------------------------------------
// Drives directed and random vectors through the block under several
// threshold settings and random sender and receiver idling. Each response
// transaction is compared field by field with a locally computed unit
// vector, length and fallback flag.
// ----------------------------------------------------------------------------
module vector3_normalize_tb
   import v3n_pkg::*;
;

   localparam int FRAC_BITS = 16;
   localparam int LATENCY   = 1 + 32 + FRAC_BITS + 1 + 1;
   localparam int WATCHDOG  = 20000;

   typedef struct {
      logic signed [UNIT_W-1:0] unit_x;
      logic signed [UNIT_W-1:0] unit_y;
      logic signed [UNIT_W-1:0] unit_z;
      logic [LEN_W-1:0]         length;
      logic                     fell_back;
   } unit_result_type;

   class norm_scoreboard;
      unit_result_type pending[$];
      logic [TINY_W-1:0] tiny;
      int mismatches;
      int checked;
      int fallbacks;

      function new();
         tiny = '0;
         mismatches = 0;
         checked = 0;
         fallbacks = 0;
      endfunction

      function logic [63:0] root64(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function logic [UNIT_W-1:0] signed_unit(logic [63:0] m, logic neg);
         logic [63:0] s;
         if (m > 64'd131071) m = 64'd131071;
         s = neg ? (64'd0 - m) : m;
         return s[UNIT_W-1:0];
      endfunction

      function void note_vector(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                                logic signed [COMP_W-1:0] z);
         logic [63:0] mag[3];
         logic neg[3];
         logic [63:0] sum;
         logic [63:0] len;
         logic signed [COMP_W-1:0] c[3];
         unit_result_type r;
         c[0] = x;
         c[1] = y;
         c[2] = z;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            neg[i] = c[i][COMP_W-1];
            mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, c[i]} : {32'd0, c[i]};
            sum = sum + mag[i] * mag[i];
         end
         len = root64(sum);
         r.length = len[LEN_W-1:0];
         if (len <= {48'd0, tiny}) begin
            r.unit_x = '0;
            r.unit_y = signed_unit(64'd1 << FRAC_BITS, 1'b0);
            r.unit_z = '0;
            r.fell_back = 1'b1;
         end else begin
            r.unit_x = signed_unit((mag[0] << FRAC_BITS) / len, neg[0]);
            r.unit_y = signed_unit((mag[1] << FRAC_BITS) / len, neg[1]);
            r.unit_z = signed_unit((mag[2] << FRAC_BITS) / len, neg[2]);
            r.fell_back = 1'b0;
         end
         pending.push_back(r);
      endfunction

      function void check_result(unit_result_type act);
         unit_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
            return;
         end
         e = pending.pop_front();
         checked++;
         if (act.fell_back) fallbacks++;
         if (act.unit_x !== e.unit_x || act.unit_y !== e.unit_y ||
             act.unit_z !== e.unit_z || act.length !== e.length ||
             act.fell_back !== e.fell_back) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp %0d %0d %0d len %0d fb %0d,",
                         " got %0d %0d %0d len %0d fb %0d"},
                        e.unit_x, e.unit_y, e.unit_z, e.length, e.fell_back,
                        act.unit_x, act.unit_y, act.unit_z, act.length, act.fell_back);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [TINY_W-1:0] csr_tiny_length = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COMP_W-1:0] req_comp_x = '0;
   logic signed [COMP_W-1:0] req_comp_y = '0;
   logic signed [COMP_W-1:0] req_comp_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [UNIT_W-1:0] rsp_unit_x;
   logic signed [UNIT_W-1:0] rsp_unit_y;
   logic signed [UNIT_W-1:0] rsp_unit_z;
   logic [LEN_W-1:0] rsp_length;
   logic rsp_fell_back;

   norm_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   int sent = 0;

   always #10 clock = ~clock;

   vector3_normalize #(.FRAC_BITS(FRAC_BITS)) i_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_tiny_length(csr_tiny_length),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_comp_x(req_comp_x), .req_comp_y(req_comp_y), .req_comp_z(req_comp_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z),
      .rsp_length(rsp_length), .rsp_fell_back(rsp_fell_back)
   );

   // response side: check at rising edge, choose stall at falling edge
   always @(posedge clock) begin
      unit_result_type act;
      if (!reset && rsp_valid && !rsp_stall) begin
         act.unit_x = rsp_unit_x;
         act.unit_y = rsp_unit_y;
         act.unit_z = rsp_unit_z;
         act.length = rsp_length;
         act.fell_back = rsp_fell_back;
         board.check_result(act);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_vector(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                              logic signed [COMP_W-1:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_vector(x, y, z);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_tiny(logic [TINY_W-1:0] v);
      drain();
      csr_write <= 1'b1;
      csr_tiny_length <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      board.tiny = v;
   endtask

   function automatic logic [COMP_W-1:0] rand_comp(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
         2: return $signed($urandom_range(64)) - 32;
         default: return $signed($urandom_range(131072)) - 65536;
      endcase
   endfunction

   task automatic random_batch(int n);
      int mode;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(3);
         send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode));
      end
   endtask

   localparam logic signed [COMP_W-1:0] CMAX = 32'sh7FFFFFFF;
   localparam logic signed [COMP_W-1:0] CMIN = 32'sh80000000;
   localparam logic signed [COMP_W-1:0] ONE  = 32'sd65536;

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero vector, extremes, axes, signs
      send_vector(0, 0, 0);
      send_vector(CMAX, CMAX, CMAX);
      send_vector(CMIN, CMIN, CMIN);
      send_vector(CMIN, 0, 0);
      send_vector(0, CMAX, 0);
      send_vector(0, 0, CMIN);
      send_vector(ONE, 0, 0);
      send_vector(-ONE, 0, 0);
      send_vector(0, -ONE, 0);
      send_vector(ONE, ONE, ONE);
      send_vector(-1, 1, -1);
      send_vector(1, 0, 0);
      send_vector(32'sh55555555, 32'shAAAAAAAA, 32'sh12345678);
      write_tiny(16'hFFFF);
      send_vector(0, 0, 0);
      send_vector(32'sd65535, 0, 0);
      send_vector(32'sd65536, 0, 0);
      send_vector(-32'sd65535, 0, 0);
      send_vector(CMIN, CMAX, 1);
      write_tiny(16'd100);
      send_vector(100, 0, 0);
      send_vector(0, -101, 0);
      send_vector(60, 60, 60);

      // pause until the pipeline is empty
      drain();

      send_idle_pct = 29;
      recv_idle_pct = 55;
      write_tiny(16'd0);
      random_batch(350);
      send_idle_pct = 55;
      recv_idle_pct = 29;
      write_tiny(TINY_W'($urandom_range(16'hFFFF)));
      random_batch(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_tiny(16'd40);
      random_batch(330);

      drain();
      $display("sent %0d vectors, checked %0d responses, %0d fallbacks, %0d mismatches",
               sent, board.checked, board.fallbacks, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
